/* rtl/trilinear_grid_sampler_defines.svh */
// assertion macros for the grid sampler
`ifndef TRILINEAR_GRID_SAMPLER_DEFINES_SVH
`define TRILINEAR_GRID_SAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TGS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define TGS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TGS_ASSERT_SAME(lbl, ante, cons, msg)
`define TGS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/tgs_pkg.sv */
package tgs_pkg;

   localparam int MAX_DIM_DEFAULT    = 64;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int COORD_BITS     = 24;
   localparam int WIDX_BITS      = 6;
   localparam int WVALUE_BITS    = 32;
   localparam int SIZE_REG_BITS  = 7;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int VOXELS         = 8;
   localparam int LERP_STEPS     = 7;
   localparam int AXES           = 3;

   localparam logic [SIZE_REG_BITS-1:0] SIZE_RESET = SIZE_REG_BITS'(64);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic MODE_TRILINEAR = 1'b0;
   localparam logic MODE_NONE      = 1'b1;

   typedef enum logic [1:0] {
      REG_SIZE_X      = 2'd0,
      REG_SIZE_Y      = 2'd1,
      REG_SIZE_Z      = 2'd2,
      REG_INTERP_MODE = 2'd3
   } reg_index_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_AXIS = 6'b000010,
      S_READ = 6'b000100,
      S_MUL  = 6'b001000,
      S_ADD  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

endpackage

/* rtl/tgs_ram.sv */
module tgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/trilinear_grid_sampler.sv */
// channel   direction  ports                                   accepted when
// req       in         operation, write_*, query_*             req_valid && req_ready
// rsp       out        result_value, saturated                 rsp_valid && rsp_ready
// csr       in/out     apb psel/penable/pwrite/paddr/pwdata    psel && penable && pready
//
// a voxel write leaves ready high for the next transaction
// a query holds ready low while it runs: eight reads through the single
// grid memory read port, then seven lerps on one shared multiplier, each a mul then an add step
// with interp_mode 1 a query answers zero in the cycle after it is taken
// reset clears control and registers only; the grid holds garbage until written
// a stalled rsp holds its value; no request is taken until it is delivered
`include "trilinear_grid_sampler_defines.svh"

module trilinear_grid_sampler #(
   parameter int MAX_DIM    = tgs_pkg::MAX_DIM_DEFAULT,
   parameter int VALUE_BITS = tgs_pkg::VALUE_BITS_DEFAULT,
   parameter int FRAC_BITS  = tgs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_operation,
   input  logic        [tgs_pkg::WIDX_BITS-1:0]     req_write_x,
   input  logic        [tgs_pkg::WIDX_BITS-1:0]     req_write_y,
   input  logic        [tgs_pkg::WIDX_BITS-1:0]     req_write_z,
   input  logic signed [tgs_pkg::WVALUE_BITS-1:0]   req_write_value,
   input  logic signed [tgs_pkg::COORD_BITS-1:0]    req_query_x,
   input  logic signed [tgs_pkg::COORD_BITS-1:0]    req_query_y,
   input  logic signed [tgs_pkg::COORD_BITS-1:0]    req_query_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [VALUE_BITS-1:0]             rsp_result_value,
   output logic                                     rsp_saturated,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic        [tgs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic        [tgs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic        [tgs_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                     csr_pready
);

   import tgs_pkg::*;

   localparam int DEPTH    = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW       = $clog2(DEPTH);
   localparam int IDX_BITS = $clog2(MAX_DIM);
   localparam int SZ_BITS  = $clog2(MAX_DIM + 1);
   localparam int SW       = (SZ_BITS > SIZE_REG_BITS) ? SZ_BITS : SIZE_REG_BITS;
   localparam int WX       = ((IDX_BITS > WIDX_BITS) ? IDX_BITS : WIDX_BITS) + 1;
   localparam int CW       = ((SZ_BITS + FRAC_BITS > COORD_BITS) ?
                              SZ_BITS + FRAC_BITS : COORD_BITS) + 1;
   localparam int BW       = CW - FRAC_BITS;
   localparam int FW       = FRAC_BITS + 2;
   localparam int IW       = VALUE_BITS + 6;
   localparam int PW       = IW + 1 + FW + 1;
   localparam int XW       = ((VALUE_BITS > WVALUE_BITS) ? VALUE_BITS : WVALUE_BITS) + 1;

   localparam logic [3:0] READ_LAST = 4'(VOXELS);
   localparam logic [2:0] LAST_STEP = 3'(LERP_STEPS - 1);

   localparam logic signed [IW-1:0] RES_MAX =
      $signed({{(IW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}});
   localparam logic signed [IW-1:0] RES_MIN =
      $signed({{(IW - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}});
   localparam logic signed [XW-1:0] WR_MAX =
      $signed({{(XW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}});
   localparam logic signed [XW-1:0] WR_MIN =
      $signed({{(XW - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}});

   function automatic logic [AW-1:0] grid_addr(input logic [IDX_BITS-1:0] x,
                                                input logic [IDX_BITS-1:0] y,
                                                input logic [IDX_BITS-1:0] z);
      grid_addr = (AW'(x) * AW'(MAX_DIM) + AW'(y)) * AW'(MAX_DIM) + AW'(z);
   endfunction

   state_type state_ff, state_in;

   logic [SIZE_REG_BITS-1:0] size_reg_ff [AXES];
   logic                     mode_ff;

   logic signed [COORD_BITS-1:0] coord_ff [AXES];
   logic        [IDX_BITS-1:0]   base_ff  [AXES];
   logic        [FW-1:0]         frac_ff  [AXES];
   logic        [IDX_BITS-1:0]   base_in  [AXES];
   logic        [FW-1:0]         frac_in  [AXES];

   logic [3:0]              rd_cnt_ff;
   logic [2:0]              step_ff;
   logic signed [IW-1:0]    q_ff [VOXELS];
   logic signed [IW-1:0]    lerp_a_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic                    rsp_sat_ff;
   logic                    rsp_valid_ff;

   logic req_accept;
   logic rsp_accept;
   logic csr_write;

   // grid write path
   logic [WX-1:0]         wx_wide, wy_wide, wz_wide;
   logic                  wr_in_range;
   logic signed [XW-1:0]  wv_wide, wv_sat;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   // lerp unit
   logic signed [IW:0]    diff;
   logic        [FW-1:0]  frac_sel;
   logic signed [FW:0]    frac_ext;
   logic signed [PW-1:0]  prod_in;
   logic signed [PW-1:0]  prod_sh;
   logic signed [IW-1:0]  sum;
   logic [2:0]            cap_idx;
   logic [2:0]            tail_idx;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_accept = rsp_valid_ff && rsp_ready;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_SIZE_X:      csr_prdata = CSR_DATA_BITS'(size_reg_ff[0]);
         REG_SIZE_Y:      csr_prdata = CSR_DATA_BITS'(size_reg_ff[1]);
         REG_SIZE_Z:      csr_prdata = CSR_DATA_BITS'(size_reg_ff[2]);
         REG_INTERP_MODE: csr_prdata = CSR_DATA_BITS'(mode_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_reg_ff[0] <= SIZE_RESET;
         size_reg_ff[1] <= SIZE_RESET;
         size_reg_ff[2] <= SIZE_RESET;
         mode_ff        <= MODE_TRILINEAR;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_SIZE_X:      size_reg_ff[0] <= csr_pwdata[SIZE_REG_BITS-1:0];
            REG_SIZE_Y:      size_reg_ff[1] <= csr_pwdata[SIZE_REG_BITS-1:0];
            REG_SIZE_Z:      size_reg_ff[2] <= csr_pwdata[SIZE_REG_BITS-1:0];
            REG_INTERP_MODE: mode_ff        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // voxel write
   assign wx_wide     = WX'(req_write_x);
   assign wy_wide     = WX'(req_write_y);
   assign wz_wide     = WX'(req_write_z);
   assign wr_in_range = (wx_wide < WX'(MAX_DIM)) && (wy_wide < WX'(MAX_DIM)) &&
                        (wz_wide < WX'(MAX_DIM));
   assign wv_wide     = XW'(req_write_value);
   assign wv_sat      = (wv_wide > WR_MAX) ? WR_MAX :
                        (wv_wide < WR_MIN) ? WR_MIN : wv_wide;
   assign ram_wr_en   = req_accept && (req_operation == OP_WRITE) && wr_in_range;
   assign ram_wr_addr = grid_addr(wx_wide[IDX_BITS-1:0], wy_wide[IDX_BITS-1:0],
                                  wz_wide[IDX_BITS-1:0]);
   assign ram_wr_data = wv_sat[VALUE_BITS-1:0];

   // corner n of the cell sits at x + n[2], y + n[1], z + n[0]
   assign ram_rd_addr = grid_addr(base_ff[0] + IDX_BITS'(rd_cnt_ff[2]),
                                  base_ff[1] + IDX_BITS'(rd_cnt_ff[1]),
                                  base_ff[2] + IDX_BITS'(rd_cnt_ff[0]));

   tgs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // per axis clamp, cell index and fraction
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic [SW-1:0]       size_raw, size_clip;
      logic [SZ_BITS-1:0]  size_eff;
      logic signed [CW-1:0] c_ext, lim, c_clamp;
      logic [BW-1:0]       b_full, b_max, b_sel;
      logic [CW-1:0]       f_full;

      assign size_raw  = SW'(size_reg_ff[a]);
      assign size_clip = (size_raw < SW'(2)) ? SW'(2) :
                         (size_raw > SW'(MAX_DIM)) ? SW'(MAX_DIM) : size_raw;
      assign size_eff  = size_clip[SZ_BITS-1:0];
      assign c_ext     = CW'(coord_ff[a]);
      assign lim       = $signed({{(CW - SZ_BITS - FRAC_BITS){1'b0}}, size_eff,
                                  {FRAC_BITS{1'b0}}});
      assign c_clamp   = (c_ext < 0) ? '0 : (c_ext > lim) ? lim : c_ext;
      assign b_full    = c_clamp[CW-1:FRAC_BITS];
      assign b_max     = BW'(size_eff - SZ_BITS'(2));
      assign b_sel     = (b_full > b_max) ? b_max : b_full;
      assign f_full    = c_clamp - {b_sel, {FRAC_BITS{1'b0}}};
      assign base_in[a] = b_sel[IDX_BITS-1:0];
      assign frac_in[a] = f_full[FW-1:0];
   end

   // lerp: a + floor((b - a) * f / 2^frac)
   always_comb begin
      if (step_ff < 3'd4) begin
         frac_sel = frac_ff[2];
      end else if (step_ff < LAST_STEP) begin
         frac_sel = frac_ff[1];
      end else begin
         frac_sel = frac_ff[0];
      end
   end

   assign diff     = (IW + 1)'(q_ff[1]) - (IW + 1)'(q_ff[0]);
   assign frac_ext = $signed({1'b0, frac_sel});
   assign prod_in  = PW'(diff) * PW'(frac_ext);
   assign prod_sh  = prod_ff >>> FRAC_BITS;
   assign sum      = lerp_a_ff + prod_sh[IW-1:0];
   assign cap_idx  = 3'(rd_cnt_ff - 4'd1);
   assign tail_idx = LAST_STEP - step_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_operation == OP_QUERY) begin
               state_in = (mode_ff == MODE_TRILINEAR) ? S_AXIS : S_OUT;
            end
         end
         S_AXIS: state_in = S_READ;
         S_READ: begin
            if (rd_cnt_ff == READ_LAST) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_ADD;
         S_ADD: begin
            if (step_ff == LAST_STEP) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         coord_ff[0]  <= req_query_x;
         coord_ff[1]  <= req_query_y;
         coord_ff[2]  <= req_query_z;
         rsp_value_ff <= '0;
         rsp_sat_ff   <= 1'b0;
      end
      if (state_ff == S_AXIS) begin
         base_ff   <= base_in;
         frac_ff   <= frac_in;
         rd_cnt_ff <= '0;
      end
      if (state_ff == S_READ) begin
         rd_cnt_ff <= rd_cnt_ff + 4'd1;
         step_ff   <= '0;
         if (rd_cnt_ff != 4'd0) begin
            q_ff[cap_idx] <= IW'($signed(ram_rd_data));
         end
      end
      if (state_ff == S_MUL) begin
         lerp_a_ff <= q_ff[0];
         prod_ff   <= prod_in;
         for (int k = 0; k < VOXELS - 2; k++) begin
            q_ff[k] <= q_ff[k + 2];
         end
      end
      if (state_ff == S_ADD) begin
         if (step_ff == LAST_STEP) begin
            if (sum > RES_MAX) begin
               rsp_value_ff <= RES_MAX[VALUE_BITS-1:0];
               rsp_sat_ff   <= 1'b1;
            end else if (sum < RES_MIN) begin
               rsp_value_ff <= RES_MIN[VALUE_BITS-1:0];
               rsp_sat_ff   <= 1'b1;
            end else begin
               rsp_value_ff <= sum[VALUE_BITS-1:0];
               rsp_sat_ff   <= 1'b0;
            end
         end else begin
            q_ff[tail_idx] <= sum;
            step_ff        <= step_ff + 3'd1;
         end
      end
   end

   `TGS_ASSERT_SAME(a_idle_no_rsp, req_ready, !rsp_valid, "rsp pending while idle")
   `TGS_ASSERT_NEXT(a_rsp_then_idle, rsp_valid && rsp_ready, req_ready, "not idle after rsp")
   `TGS_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_operation == OP_QUERY,
                    !req_ready, "ready after query transaction")
   `TGS_ASSERT_SAME(a_step_range, state_ff == S_MUL || state_ff == S_ADD,
                    step_ff <= LAST_STEP, "lerp step out of range")

endmodule

/* sim/trilinear_grid_sampler_tb.sv */
module trilinear_grid_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tgs_pkg::*;

   localparam int GRID_DIM         = MAX_DIM_DEFAULT;
   localparam int GRID_VOXELS      = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int FRAC             = FRAC_BITS_DEFAULT;
   localparam int SAMPLE_BITS      = VALUE_BITS_DEFAULT;
   localparam int ITEM_TARGET      = 1850;
   localparam int PHASE_ITEMS      = 150;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam longint SAMPLE_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;

   typedef struct {
      logic                          operation;
      logic [WIDX_BITS-1:0]          write_x;
      logic [WIDX_BITS-1:0]          write_y;
      logic [WIDX_BITS-1:0]          write_z;
      logic signed [WVALUE_BITS-1:0] write_value;
      logic signed [COORD_BITS-1:0]  query_x;
      logic signed [COORD_BITS-1:0]  query_y;
      logic signed [COORD_BITS-1:0]  query_z;
   } grid_op_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          saturated;
   } sample_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_operation = OP_WRITE;
   logic [WIDX_BITS-1:0]          req_write_x = '0;
   logic [WIDX_BITS-1:0]          req_write_y = '0;
   logic [WIDX_BITS-1:0]          req_write_z = '0;
   logic signed [WVALUE_BITS-1:0] req_write_value = '0;
   logic signed [COORD_BITS-1:0]  req_query_x = '0;
   logic signed [COORD_BITS-1:0]  req_query_y = '0;
   logic signed [COORD_BITS-1:0]  req_query_z = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_result_value;
   logic                          rsp_saturated;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;

   grid_op_type               pending_ops[$];
   sample_result_type         expected_samples[$];
   logic signed [31:0]        grid_image [GRID_VOXELS];
   bit                        voxel_written [GRID_VOXELS];
   logic [SIZE_REG_BITS-1:0]  size_reg [AXES];
   logic                      mode_reg;
   int                        failures = 0;
   int                        idle_cycles = 0;
   int                        items_queued = 0;
   int                        send_gap = 0;
   int                        stall_left = 0;
   int                        hold_left = 0;
   bit                        hold_started = 1'b0;
   bit                        hold_off_req = 1'b0;
   bit                        calm = 1'b0;

   trilinear_grid_sampler uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned size_in_use(logic [SIZE_REG_BITS-1:0] r);
      if (r < 2) return 2;
      if (r > GRID_DIM) return GRID_DIM;
      return r;
   endfunction

   function automatic int unsigned voxel_index(int unsigned i, int unsigned j, int unsigned k);
      return (i * GRID_DIM + j) * GRID_DIM + k;
   endfunction

   // clamp to [0, extent], cell index limited to extent-2, fraction may reach 2.0
   function automatic void split_axis(input logic signed [COORD_BITS-1:0] raw,
                                      input int unsigned extent,
                                      output int unsigned base, output longint frac);
      longint c;
      longint lim;
      c = raw;
      lim = longint'(extent) << FRAC;
      if (c < 0) c = 0;
      if (c > lim) c = lim;
      base = int'(c >>> FRAC);
      if (base > extent - 2) base = extent - 2;
      frac = c - (longint'(base) << FRAC);
   endfunction

   function automatic longint blend(longint a, longint b, longint f);
      return a + (((b - a) * f) >>> FRAC);
   endfunction

   function automatic longint voxel_at(int unsigned i, int unsigned j, int unsigned k);
      return longint'(grid_image[voxel_index(i, j, k)]);
   endfunction

   function automatic sample_result_type predict_sample(logic signed [COORD_BITS-1:0] qx,
                                                        logic signed [COORD_BITS-1:0] qy,
                                                        logic signed [COORD_BITS-1:0] qz);
      int unsigned bx, by, bz;
      longint fx, fy, fz, y0, y1, r;
      sample_result_type res;
      res.value = '0;
      res.saturated = 1'b0;
      if (mode_reg == MODE_NONE) return res;
      split_axis(qx, size_in_use(size_reg[0]), bx, fx);
      split_axis(qy, size_in_use(size_reg[1]), by, fy);
      split_axis(qz, size_in_use(size_reg[2]), bz, fz);
      y0 = blend(blend(voxel_at(bx, by, bz), voxel_at(bx, by, bz + 1), fz),
                 blend(voxel_at(bx, by + 1, bz), voxel_at(bx, by + 1, bz + 1), fz), fy);
      y1 = blend(blend(voxel_at(bx + 1, by, bz), voxel_at(bx + 1, by, bz + 1), fz),
                 blend(voxel_at(bx + 1, by + 1, bz), voxel_at(bx + 1, by + 1, bz + 1), fz),
                 fy);
      r = blend(y0, y1, fx);
      if (r > SAMPLE_MAX) begin
         r = SAMPLE_MAX;
         res.saturated = 1'b1;
      end else if (r < SAMPLE_MIN) begin
         r = SAMPLE_MIN;
         res.saturated = 1'b1;
      end
      res.value = SAMPLE_BITS'(r);
      return res;
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] random_coord(int unsigned extent);
      case ($urandom_range(0, 9))
         0: return COORD_BITS'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 24'h7F_FFFF : 24'h80_0000;
         2: return COORD_BITS'($urandom_range(0, extent) << FRAC);
         3: return COORD_BITS'(((extent - 1) << FRAC) + $urandom_range(0, 2 << FRAC));
         4: return COORD_BITS'(-$urandom_range(1, 1 << FRAC));
         default: return COORD_BITS'($urandom_range(0, extent << FRAC));
      endcase
   endfunction

   function automatic logic [SIZE_REG_BITS-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return SIZE_REG_BITS'(GRID_DIM);
         1: return SIZE_REG_BITS'($urandom_range(GRID_DIM + 1, 127));
         2: return SIZE_REG_BITS'($urandom_range(0, 1));
         3: return SIZE_REG_BITS'($urandom_range(5, GRID_DIM - 1));
         default: return SIZE_REG_BITS'($urandom_range(2, 4));
      endcase
   endfunction

   function automatic void queue_write(int unsigned x, int unsigned y, int unsigned z,
                                       logic [31:0] value);
      grid_op_type op;
      op.operation = OP_WRITE;
      op.write_x = WIDX_BITS'(x);
      op.write_y = WIDX_BITS'(y);
      op.write_z = WIDX_BITS'(z);
      op.write_value = value;
      op.query_x = COORD_BITS'($urandom);
      op.query_y = COORD_BITS'($urandom);
      op.query_z = COORD_BITS'($urandom);
      pending_ops.push_back(op);
      voxel_written[voxel_index(x, y, z)] = 1'b1;
      items_queued++;
   endfunction

   // any corner of the addressed cell that was never loaded gets a write first
   function automatic void queue_query(logic signed [COORD_BITS-1:0] qx,
                                       logic signed [COORD_BITS-1:0] qy,
                                       logic signed [COORD_BITS-1:0] qz);
      grid_op_type op;
      int unsigned bx, by, bz;
      longint fx, fy, fz;
      split_axis(qx, size_in_use(size_reg[0]), bx, fx);
      split_axis(qy, size_in_use(size_reg[1]), by, fy);
      split_axis(qz, size_in_use(size_reg[2]), bz, fz);
      for (int dx = 0; dx < 2; dx++)
         for (int dy = 0; dy < 2; dy++)
            for (int dz = 0; dz < 2; dz++)
               if (!voxel_written[voxel_index(bx + dx, by + dy, bz + dz)])
                  queue_write(bx + dx, by + dy, bz + dz, random_sample());
      op.operation = OP_QUERY;
      op.write_x = WIDX_BITS'($urandom);
      op.write_y = WIDX_BITS'($urandom);
      op.write_z = WIDX_BITS'($urandom);
      op.write_value = $urandom;
      op.query_x = qx;
      op.query_y = qy;
      op.query_z = qz;
      pending_ops.push_back(op);
      items_queued++;
   endfunction

   // stops early once the running item count reaches the budget
   function automatic void run_random_phase(int count, int budget);
      int unsigned sx, sy, sz;
      int n;
      sx = size_in_use(size_reg[0]);
      sy = size_in_use(size_reg[1]);
      sz = size_in_use(size_reg[2]);
      n = 0;
      while (n < count && items_queued < budget) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:
               queue_write($urandom_range(0, sx - 1), $urandom_range(0, sy - 1),
                           $urandom_range(0, sz - 1), random_sample());
            7, 8:
               queue_write($urandom_range(0, GRID_DIM - 1), $urandom_range(0, GRID_DIM - 1),
                           $urandom_range(0, GRID_DIM - 1), random_sample());
            default:
               queue_query(random_coord(sx), random_coord(sy), random_coord(sz));
         endcase
         n++;
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(logic [SIZE_REG_BITS-1:0] sx, logic [SIZE_REG_BITS-1:0] sy,
                            logic [SIZE_REG_BITS-1:0] sz, logic mode);
      wait_drained();
      csr_write(REG_SIZE_X, CSR_DATA_BITS'(sx));
      csr_write(REG_SIZE_Y, CSR_DATA_BITS'(sy));
      csr_write(REG_SIZE_Z, CSR_DATA_BITS'(sz));
      csr_write(REG_INTERP_MODE, CSR_DATA_BITS'(mode));
      @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      grid_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_operation <= op.operation;
            req_write_x <= op.write_x;
            req_write_y <= op.write_y;
            req_write_z <= op.write_z;
            req_write_value <= op.write_value;
            req_query_x <= op.query_x;
            req_query_y <= op.query_y;
            req_query_z <= op.query_z;
            if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_req && !hold_started) begin
         hold_started = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      sample_result_type want;
      if (reset) begin
         size_reg[0] = SIZE_RESET;
         size_reg[1] = SIZE_RESET;
         size_reg[2] = SIZE_RESET;
         mode_reg = MODE_TRILINEAR;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (csr_psel) idle_cycles = 0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_SIZE_X: size_reg[0] = csr_pwdata[SIZE_REG_BITS-1:0];
               REG_SIZE_Y: size_reg[1] = csr_pwdata[SIZE_REG_BITS-1:0];
               REG_SIZE_Z: size_reg[2] = csr_pwdata[SIZE_REG_BITS-1:0];
               REG_INTERP_MODE: mode_reg = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            if (req_operation == OP_WRITE)
               grid_image[voxel_index(req_write_x, req_write_y, req_write_z)] = req_write_value;
            else
               expected_samples.push_back(predict_sample(req_query_x, req_query_y,
                                                         req_query_z));
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_samples.size() == 0) begin
               $error("unexpected transaction: result_value %0d saturated %0b",
                      rsp_result_value, rsp_saturated);
               failures++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d", want.value,
                         rsp_result_value);
                  failures++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b", want.saturated,
                         rsp_saturated);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      do @(negedge clock);
      while (idle_cycles < WATCHDOG_LIMIT);
      $display("FAIL trilinear_grid_sampler");
      $finish;
   end

   initial begin
      int phase;
      phase = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // low register values clamp to the smallest grid, one cell
      configure(0, 1, 2, MODE_TRILINEAR);
      queue_write(0, 0, 0, 32'h8000_0000);
      queue_write(0, 0, 1, 32'h7FFF_FFFF);
      queue_write(0, 1, 0, 32'h0000_0000);
      queue_write(0, 1, 1, 32'hFFFF_FFFF);
      queue_write(1, 0, 0, 32'h0000_0001);
      queue_write(1, 0, 1, 32'h0001_0000);
      queue_write(1, 1, 0, 32'h7FFF_FFFF);
      queue_write(1, 1, 1, 32'h8000_0000);
      queue_query(24'sh80_0000, 24'sh80_0000, 24'sh80_0000);
      queue_query(24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF);
      queue_query(24'sh01_0000, 24'sh01_0000, 24'sh01_0000);
      // extrapolation past the last voxel, both saturation directions
      queue_query(24'sh00_0000, 24'sh00_0000, 24'sh02_0000);
      queue_query(24'sh01_0000, 24'sh01_0000, 24'sh02_0000);
      queue_query(24'sh00_FFFF, 24'sh00_8000, 24'sh00_0001);
      queue_query(24'sh02_0000, 24'sh00_0000, 24'sh01_8000);
      queue_query(24'shFF_FFFF, 24'sh01_FFFF, 24'sh02_0001);
      // stored even though outside the extent in use
      queue_write(63, 63, 63, random_sample());
      queue_write(1, 1, 1, 32'h0000_0000);
      queue_query(24'sh01_0000, 24'sh01_0000, 24'sh01_0000);

      configure(0, 1, 2, MODE_NONE);
      queue_query(24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF);
      queue_query(24'sh00_8000, 24'sh80_0000, 24'sh01_0000);

      configure(127, 64, 65, MODE_TRILINEAR);
      run_random_phase(PHASE_ITEMS, ITEM_TARGET - PHASE_ITEMS);

      while (items_queued < ITEM_TARGET - PHASE_ITEMS) begin
         configure(pick_size(), pick_size(), pick_size(),
                   ($urandom_range(0, 5) == 0) ? MODE_NONE : MODE_TRILINEAR);
         run_random_phase(PHASE_ITEMS, ITEM_TARGET - PHASE_ITEMS);
         if (phase == 0) hold_off_req = 1'b1;
         phase++;
      end

      configure(pick_size(), pick_size(), pick_size(), MODE_TRILINEAR);
      calm = 1'b1;
      run_random_phase(PHASE_ITEMS, ITEM_TARGET);
      wait_drained();

      if (failures == 0) $display("PASS trilinear_grid_sampler");
      else $display("FAIL trilinear_grid_sampler");
      $finish;
   end

endmodule
